[rtl/core/change_triggered_trace_ring_unit_macros.svh]
// assertion macros for the trace ring unit
`ifndef CHANGE_TRIGGERED_TRACE_RING_UNIT_MACROS_SVH
`define CHANGE_TRIGGERED_TRACE_RING_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CTTR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trace ring check failed");

// implication with the consequence delayed after the antecedent
`define CTTR_ASSERT_DLY2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("trace ring latency check failed");

`endif

[rtl/core/cttr_pkg.sv]
// shared types and constants for the trace ring unit
package cttr_pkg;

    localparam int DEPTH_DEF = 256;

    localparam logic [15:0] SAMPLE_IV_RST = 16'd100;
    localparam logic [15:0] HEARTBEAT_RST = 16'd1000;

    localparam logic [2:0] MODE_SAMPLE = 3'd0;
    localparam logic [2:0] MODE_START  = 3'd1;
    localparam logic [2:0] MODE_STOP   = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    localparam logic REG_SAMPLE_IV = 1'b0;
    localparam logic REG_HEARTBEAT = 1'b1;

    typedef enum logic [2:0] {
        CMD_SAMPLE,
        CMD_START,
        CMD_STOP,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] duty_set;
        logic signed [15:0] duty_actual;
        logic signed [15:0] target_power;
        logic [7:0]         pilot_state;
        logic [7:0]         status_bits;
    } t_sample;

    typedef struct packed {
        logic [31:0] elapsed_ms;
        t_sample     sample;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] now_ms;
        t_sample     sample;
        logic [7:0]  read_position;
    } t_item;

    typedef struct packed {
        logic [15:0] sample_iv;
        logic [15:0] heartbeat;
    } t_cfg;

endpackage

[rtl/core/cttr_ram.sv]
// generic single-write, single-read ram with registered read data
module cttr_ram #(
    parameter int WIDTH = cttr_pkg::REC_W,
    parameter int DEPTH = cttr_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/cttr_front.sv]
// command front end: accepts beats, decodes the mode and queues up to two items
module cttr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_mode,
    input  logic [31:0]        i_now_ms,
    input  logic signed [15:0] i_duty_set,
    input  logic signed [15:0] i_duty_actual,
    input  logic signed [15:0] i_target_power,
    input  logic [7:0]         i_pilot_state,
    input  logic [7:0]         i_status_bits,
    input  logic [7:0]         i_read_position,
    input  logic               i_pop,
    output cttr_pkg::t_item    o_item,
    output logic               o_item_valid
);
    import cttr_pkg::*;

    t_item      r_q [2];
    logic       r_head;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push;
    logic       tail;
    t_item      in_item;
    t_cmd       cmd;

    always_comb begin
        case (i_mode)
            MODE_SAMPLE: cmd = CMD_SAMPLE;
            MODE_START:  cmd = CMD_START;
            MODE_STOP:   cmd = CMD_STOP;
            MODE_CLEAR:  cmd = CMD_CLEAR;
            MODE_READ:   cmd = CMD_READ;
            default:     cmd = CMD_NOP;
        endcase
    end

    always_comb begin
        in_item                     = '0;
        in_item.cmd                 = cmd;
        in_item.now_ms              = i_now_ms;
        in_item.sample.duty_set     = i_duty_set;
        in_item.sample.duty_actual  = i_duty_actual;
        in_item.sample.target_power = i_target_power;
        in_item.sample.pilot_state  = i_pilot_state;
        in_item.sample.status_bits  = i_status_bits;
        in_item.read_position       = i_read_position;
    end

    assign o_busy       = (r_cnt == 2'd2);
    assign push         = i_start && !o_busy;
    assign tail         = r_head ^ r_cnt[0];
    assign o_item       = r_q[r_head];
    assign o_item_valid = (r_cnt != 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        case ({push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_pop) begin
                r_head <= ~r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[tail] <= in_item;
        end
    end
endmodule

[rtl/core/cttr_back.sv]
// execution back end: ring pointers, sample filtering, record store and read-out
module cttr_back #(
    parameter int LOG_DEPTH = cttr_pkg::DEPTH_DEF,
    localparam int CW = $clog2(LOG_DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cttr_pkg::t_cfg  i_cfg,
    input  cttr_pkg::t_item i_item,
    input  logic            i_item_valid,
    output logic            o_pop,
    output logic            o_valid,
    output logic            o_stored,
    output logic            o_recording,
    output logic [CW-1:0]   o_entry_count,
    output logic            o_read_valid,
    output cttr_pkg::t_rec  o_entry
);
    import cttr_pkg::*;

    localparam int PW = $clog2(LOG_DEPTH);
    localparam int SW = CW + 9;

    typedef enum logic [1:0] {
        ST_ISSUE = 2'b01,
        ST_EXEC  = 2'b10
    } t_state;

    t_state        r_state;
    t_state        n_state;
    t_item         r_item;
    logic [PW-1:0] r_wp;
    logic [PW-1:0] n_wp;
    logic [CW-1:0] r_held;
    logic [CW-1:0] n_held;
    logic          r_active;
    logic          n_active;
    logic [31:0]   r_start_time;
    logic [31:0]   n_start_time;
    logic [31:0]   r_last_sample;
    logic [31:0]   n_last_sample;
    logic [31:0]   r_last_store;
    logic [31:0]   n_last_store;

    logic          r_valid;
    logic          n_valid;
    logic          r_stored;
    logic          n_stored;
    logic          r_rvalid;
    logic          n_rvalid;
    t_rec          r_entry;
    t_rec          n_entry;

    logic [SW-1:0] oldest;
    logic [SW-1:0] rd_pos;
    logic [PW-1:0] prev;
    logic [PW-1:0] raddr;
    logic          we;
    t_rec          wrec;
    t_rec          rd_rec;
    logic [REC_W-1:0] rdata;

    // read address, worked out in the issue cycle
    always_comb begin
        oldest = SW'(r_wp) + SW'(LOG_DEPTH) - SW'(r_held);
        if (oldest >= SW'(LOG_DEPTH)) begin
            oldest = oldest - SW'(LOG_DEPTH);
        end
        rd_pos = oldest + SW'(i_item.read_position);
        if (rd_pos >= SW'(LOG_DEPTH)) begin
            rd_pos = rd_pos - SW'(LOG_DEPTH);
        end
        prev  = (r_wp == '0) ? PW'(LOG_DEPTH - 1) : r_wp - PW'(1);
        raddr = (i_item.cmd == CMD_READ) ? rd_pos[PW-1:0] : prev;
    end

    assign o_pop  = (r_state == ST_ISSUE) && i_item_valid;
    assign rd_rec = t_rec'(rdata);

    cttr_ram #(
        .WIDTH (REC_W),
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (REC_W'(wrec)),
        .i_re    (o_pop),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        logic [31:0] since_sample;
        logic [31:0] since_store;
        logic        held_back;
        logic        changed;
        logic        beat;
        logic        in_range;

        n_state       = r_state;
        n_wp          = r_wp;
        n_held        = r_held;
        n_active      = r_active;
        n_start_time  = r_start_time;
        n_last_sample = r_last_sample;
        n_last_store  = r_last_store;
        n_valid       = 1'b0;
        n_stored      = 1'b0;
        n_rvalid      = 1'b0;
        n_entry       = '0;
        we            = 1'b0;

        wrec.elapsed_ms = r_item.now_ms - r_start_time;
        wrec.sample     = r_item.sample;

        since_sample = r_item.now_ms - r_last_sample;
        since_store  = r_item.now_ms - r_last_store;
        held_back    = (r_last_sample != 32'd0) && (since_sample < {16'd0, i_cfg.sample_iv});
        changed      = (r_held == '0) || (rd_rec.sample != r_item.sample);
        beat         = (r_held == '0) || (since_store >= {16'd0, i_cfg.heartbeat});
        in_range     = SW'(r_item.read_position) < SW'(r_held);

        case (r_state)
            ST_ISSUE: begin
                if (o_pop) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_ISSUE;
                n_valid = 1'b1;
                case (r_item.cmd)
                    CMD_SAMPLE: begin
                        if (r_active && !held_back) begin
                            n_last_sample = r_item.now_ms;
                            if (changed || beat) begin
                                we           = 1'b1;
                                n_wp         = (r_wp == PW'(LOG_DEPTH - 1)) ? '0
                                                                            : r_wp + PW'(1);
                                n_held       = (r_held == CW'(LOG_DEPTH)) ? r_held
                                                                          : r_held + CW'(1);
                                n_last_store = r_item.now_ms;
                                n_stored     = 1'b1;
                            end
                        end
                    end
                    CMD_START, CMD_CLEAR: begin
                        n_wp          = '0;
                        n_held        = '0;
                        n_start_time  = r_item.now_ms;
                        n_last_sample = 32'd0;
                        n_last_store  = 32'd0;
                        if (r_item.cmd == CMD_START) begin
                            n_active = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        n_active = 1'b0;
                    end
                    CMD_READ: begin
                        if (in_range) begin
                            n_rvalid = 1'b1;
                            n_entry  = rd_rec;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = ST_ISSUE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_ISSUE;
            r_wp          <= '0;
            r_held        <= '0;
            r_active      <= 1'b0;
            r_start_time  <= 32'd0;
            r_last_sample <= 32'd0;
            r_last_store  <= 32'd0;
            r_valid       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_wp          <= n_wp;
            r_held        <= n_held;
            r_active      <= n_active;
            r_start_time  <= n_start_time;
            r_last_sample <= n_last_sample;
            r_last_store  <= n_last_store;
            r_valid       <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        r_stored <= n_stored;
        r_rvalid <= n_rvalid;
        r_entry  <= n_entry;
    end

    // all from registers; recording and count hold, the result fields fall back to zero
    assign o_valid       = r_valid;
    assign o_stored      = r_stored;
    assign o_recording   = r_active;
    assign o_entry_count = r_held;
    assign o_read_valid  = r_rvalid;
    assign o_entry       = r_entry;
endmodule

[rtl/core/change_triggered_trace_ring_unit.sv]
// top level of the change-triggered trace ring unit
//
// commands enter on start/busy: a beat is taken at a clock edge with start
// high and busy low. i_mode picks sample, start, stop, clear or read entry;
// the other fields carry the sample, its timestamp and the read position.
// a two-entry command queue sits in front of the executing back end, so
// busy rises only when both queue slots are taken.
// each command gives exactly one result beat, shown for one cycle with
// o_valid high. the receiver cannot hold results off and must take every
// beat as it comes.
// when the back end is free, an accepted beat goes from the queue to issue,
// then exec, and o_valid is registered from exec. issue does one ram read
// of the last or the addressed record, exec the compare and the record
// write; no new command is popped until the back end is back in issue.
// the two interval registers sit on an apb port at byte addresses 0 and 4;
// write them only while no command is in flight.
// reset empties the queue, stops recording and zeroes the ring pointers and
// times; registers return to 100 and 1000 ms. ring contents are not cleared
// and there is no clearing pass: only entries written since the last start
// or clear can be read.
`include "change_triggered_trace_ring_unit_macros.svh"

module change_triggered_trace_ring_unit #(
    parameter int LOG_DEPTH = cttr_pkg::DEPTH_DEF,
    localparam int CW = $clog2(LOG_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_mode,
    input  logic [31:0]        i_now_ms,
    input  logic signed [15:0] i_duty_set,
    input  logic signed [15:0] i_duty_actual,
    input  logic signed [15:0] i_target_power,
    input  logic [7:0]         i_pilot_state,
    input  logic [7:0]         i_status_bits,
    input  logic [7:0]         i_read_position,

    output logic               o_valid,
    output logic               o_stored,
    output logic               o_recording,
    output logic [CW-1:0]      o_entry_count,
    output logic               o_read_valid,
    output logic [31:0]        o_entry_elapsed_ms,
    output logic signed [15:0] o_entry_duty_set,
    output logic signed [15:0] o_entry_duty_actual,
    output logic signed [15:0] o_entry_target_power,
    output logic [7:0]         o_entry_pilot_state,
    output logic [7:0]         o_entry_status_bits,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cttr_pkg::*;

    t_cfg  r_cfg;
    logic  cfg_we;
    t_item item;
    logic  item_valid;
    logic  pop;
    t_rec  entry;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEARTBEAT) ? {16'd0, r_cfg.heartbeat}
                                                : {16'd0, r_cfg.sample_iv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_iv <= SAMPLE_IV_RST;
            r_cfg.heartbeat <= HEARTBEAT_RST;
        end else if (cfg_we) begin
            if (paddr[2] == REG_HEARTBEAT) begin
                r_cfg.heartbeat <= pwdata[15:0];
            end else begin
                r_cfg.sample_iv <= pwdata[15:0];
            end
        end
    end

    cttr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_mode          (i_mode),
        .i_now_ms        (i_now_ms),
        .i_duty_set      (i_duty_set),
        .i_duty_actual   (i_duty_actual),
        .i_target_power  (i_target_power),
        .i_pilot_state   (i_pilot_state),
        .i_status_bits   (i_status_bits),
        .i_read_position (i_read_position),
        .i_pop           (pop),
        .o_item          (item),
        .o_item_valid    (item_valid)
    );

    cttr_back #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item        (item),
        .i_item_valid  (item_valid),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_stored      (o_stored),
        .o_recording   (o_recording),
        .o_entry_count (o_entry_count),
        .o_read_valid  (o_read_valid),
        .o_entry       (entry)
    );

    assign o_entry_elapsed_ms   = entry.elapsed_ms;
    assign o_entry_duty_set     = entry.sample.duty_set;
    assign o_entry_duty_actual  = entry.sample.duty_actual;
    assign o_entry_target_power = entry.sample.target_power;
    assign o_entry_pilot_state  = entry.sample.pilot_state;
    assign o_entry_status_bits  = entry.sample.status_bits;

    `CTTR_ASSERT_DLY2(a_pop_to_result, i_clk, i_rst_n, pop, o_valid)
    `CTTR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_valid, o_entry_count <= CW'(LOG_DEPTH))
    `CTTR_ASSERT_NOW(a_store_while_rec, i_clk, i_rst_n, o_valid && o_stored, o_recording && !o_read_valid)
    `CTTR_ASSERT_NOW(a_read_nonempty, i_clk, i_rst_n, o_valid && o_read_valid, o_entry_count != '0)
endmodule
